FILE: hdl/dcs_pkg.sv
// Shared types and constants of the decimal string to fixed point parser.
// Used by every module of the block; depends on nothing.
package dcs_pkg;

    localparam int LIMB_W          = 64;
    localparam int RES_LIMBS       = 4;
    localparam int RES_W           = LIMB_W * RES_LIMBS;
    localparam int LIMB_COUNT_DEF  = 4;
    localparam int MAX_SCALE_DEF   = 76;
    localparam int SCALE_W         = 7;
    localparam int MODE_W          = 2;
    localparam int DIGIT_W         = 4;
    localparam int CHAR_W          = 8;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 8;
    localparam int QUEUE_DEPTH     = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SCALE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_MODE = 2'd1;

    // Result range codes.
    localparam logic [MODE_W-1:0] MODE_64  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_128 = 2'd1;
    localparam logic [MODE_W-1:0] MODE_256 = 2'd2;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 7'd0;
    localparam logic [MODE_W-1:0]  MODE_RESET  = MODE_128;

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              char_present;
        logic              is_last;
    } dcs_in_t;

    typedef struct packed {
        logic [LIMB_W-1:0] limb0;
        logic [LIMB_W-1:0] limb1;
        logic [LIMB_W-1:0] limb2;
        logic [LIMB_W-1:0] limb3;
        logic              ok;
    } dcs_out_t;

    // Work handed from the classifier to the accumulator.
    typedef struct packed {
        logic               has_digit;
        logic [DIGIT_W-1:0] digit;
        logic               is_end;
        logic               negative;
        logic               bad;
        logic [SCALE_W-1:0] pad;
    } dcs_cmd_t;

endpackage

FILE: hdl/dcs_queue.sv
// Short word queue between the classifier and the accumulator.
// Depends on dcs_pkg for the command word type and the depth.
module dcs_queue
    import dcs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_en,
    input  dcs_cmd_t wr_data,
    input  logic     rd_en,
    output dcs_cmd_t rd_data,
    output logic     full,
    output logic     empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    dcs_cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: hdl/dcs_front.sv
// Character classifier: tracks sign, dot, fraction count and syntax errors,
// and emits digit and end-of-string words. Depends on dcs_pkg.
module dcs_front
    import dcs_pkg::*;
#(
    parameter int MAX_SCALE = MAX_SCALE_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  dcs_in_t            item,
    input  logic [SCALE_W-1:0] scale,
    output logic               cmd_push,
    output dcs_cmd_t           cmd
);

    logic               in_body_reg, in_body_next;
    logic               negative_reg, negative_next;
    logic               seen_digit_reg, seen_digit_next;
    logic               seen_dot_reg, seen_dot_next;
    logic [SCALE_W-1:0] frac_reg, frac_next;
    logic               failed_reg, failed_next;
    logic [SCALE_W-1:0] eff_scale;
    logic               general;
    logic               is_digit;

    assign eff_scale = (scale > SCALE_W'(MAX_SCALE)) ? SCALE_W'(MAX_SCALE) : scale;
    assign is_digit  = item.char_code inside {[CH_ZERO:CH_NINE]};

    always_comb
    begin
        in_body_next    = in_body_reg;
        negative_next   = negative_reg;
        seen_digit_next = seen_digit_reg;
        seen_dot_next   = seen_dot_reg;
        frac_next       = frac_reg;
        failed_next     = failed_reg;
        general         = 1'b0;
        cmd             = '0;
        cmd.digit       = DIGIT_W'(item.char_code - CH_ZERO);

        if (take)
        begin
            // Once a syntax error is seen the rest of the string is ignored.
            if (item.char_present && !failed_reg)
            begin
                general = 1'b1;
                if (!in_body_reg)
                begin
                    if (item.char_code == CH_SPACE || item.char_code == CH_TAB)
                    begin
                        general = 1'b0;
                    end
                    else
                    begin
                        in_body_next = 1'b1;
                        if (item.char_code == CH_PLUS || item.char_code == CH_MINUS)
                        begin
                            negative_next = (item.char_code == CH_MINUS);
                            general       = 1'b0;
                        end
                    end
                end

                if (general)
                begin
                    if (item.char_code == CH_DOT)
                    begin
                        if (seen_dot_reg)
                        begin
                            failed_next = 1'b1;
                        end
                        else
                        begin
                            seen_dot_next = 1'b1;
                        end
                    end
                    else if (!is_digit)
                    begin
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        seen_digit_next = 1'b1;
                        if (!seen_dot_reg)
                        begin
                            cmd.has_digit = 1'b1;
                        end
                        else if (frac_reg < eff_scale)
                        begin
                            // Fraction digits past the scale are checked but dropped.
                            frac_next     = frac_reg + 1'b1;
                            cmd.has_digit = 1'b1;
                        end
                    end
                end
            end

            if (item.is_last)
            begin
                cmd.is_end   = 1'b1;
                cmd.negative = negative_next;
                cmd.bad      = failed_next || !seen_digit_next;
                cmd.pad      = (frac_next < eff_scale) ? eff_scale - frac_next : '0;
                in_body_next    = 1'b0;
                negative_next   = 1'b0;
                seen_digit_next = 1'b0;
                seen_dot_next   = 1'b0;
                frac_next       = '0;
                failed_next     = 1'b0;
            end
        end
    end

    assign cmd_push = cmd.has_digit || cmd.is_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_body_reg    <= 1'b0;
            negative_reg   <= 1'b0;
            seen_digit_reg <= 1'b0;
            seen_dot_reg   <= 1'b0;
            frac_reg       <= '0;
            failed_reg     <= 1'b0;
        end
        else
        begin
            in_body_reg    <= in_body_next;
            negative_reg   <= negative_next;
            seen_digit_reg <= seen_digit_next;
            seen_dot_reg   <= seen_dot_next;
            frac_reg       <= frac_next;
            failed_reg     <= failed_next;
        end
    end

endmodule

FILE: hdl/dcs_back.sv
// Accumulator: multiply-by-ten-and-add, scale padding, range check, sign and
// the result register. Depends on dcs_pkg.
module dcs_back
    import dcs_pkg::*;
#(
    parameter int LIMB_COUNT = LIMB_COUNT_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  dcs_cmd_t          cmd,
    output logic              cmd_pop,
    input  logic [MODE_W-1:0] width_mode,
    input  logic              pop,
    output logic              empty,
    output dcs_out_t          result
);

    localparam int MAG_W  = LIMB_W * LIMB_COUNT;
    localparam int EXT_W  = MAG_W + 4;
    localparam int LCNT_W = 3;

    typedef enum logic [2:0] {
        S_RUN  = 3'b001,
        S_PAD  = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [MAG_W-1:0]   mag_reg, mag_next;
    logic               ovf_reg, ovf_next;
    logic               neg_reg, neg_next;
    logic               bad_reg, bad_next;
    logic [SCALE_W-1:0] pad_reg, pad_next;
    dcs_out_t           out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    logic [LCNT_W-1:0]  acc_limbs, res_limbs;
    logic [MAG_W-1:0]   acc_mask, res_mask, high_mask, top_bit;
    logic [EXT_W-1:0]   mag_ext, step_sum;
    logic [DIGIT_W-1:0] addend;
    logic               step_ovf;
    logic               in_range;
    logic [MAG_W-1:0]   signed_mag;
    logic [RES_W-1:0]   res_full;

    always_comb
    begin
        case (width_mode)
            MODE_64:  res_limbs = LCNT_W'(1);
            MODE_128: res_limbs = LCNT_W'(2);
            default:  res_limbs = LCNT_W'(4);
        endcase
        acc_limbs = (width_mode == MODE_64 || width_mode == MODE_128) ? LCNT_W'(2)
                                                                       : LCNT_W'(4);
        if (res_limbs > LCNT_W'(LIMB_COUNT))
        begin
            res_limbs = LCNT_W'(LIMB_COUNT);
        end
        if (acc_limbs > LCNT_W'(LIMB_COUNT))
        begin
            acc_limbs = LCNT_W'(LIMB_COUNT);
        end
        for (int i = 0; i < LIMB_COUNT; i++)
        begin
            acc_mask[i*LIMB_W +: LIMB_W] = {LIMB_W{LCNT_W'(i) < acc_limbs}};
            res_mask[i*LIMB_W +: LIMB_W] = {LIMB_W{LCNT_W'(i) < res_limbs}};
        end
    end

    // Bits from the sign position up, and the sign position alone.
    assign high_mask = ~(res_mask >> 1);
    assign top_bit   = res_mask & ~(res_mask >> 1);

    // One shared unit: magnitude * 10 + addend over the full width, with the
    // carry-out judged against the current accumulator width.
    assign addend   = state_reg == S_RUN ? cmd.digit : '0;
    assign mag_ext  = EXT_W'(mag_reg);
    assign step_sum = (mag_ext << 3) + (mag_ext << 1) + EXT_W'(addend);
    assign step_ovf = |(step_sum & ~{4'b0000, acc_mask});

    assign in_range   = ((mag_reg & high_mask) == '0) || (neg_reg && mag_reg == top_bit);
    assign signed_mag = (neg_reg ? (~mag_reg) + MAG_W'(1) : mag_reg) & res_mask;
    assign res_full   = RES_W'(signed_mag);

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        ovf_next       = ovf_reg;
        neg_next       = neg_reg;
        bad_next       = bad_reg;
        pad_next       = pad_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;
        cmd_pop        = 1'b0;

        case (state_reg)
            S_RUN:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.has_digit && !ovf_reg)
                    begin
                        mag_next = step_sum[MAG_W-1:0];
                        ovf_next = step_ovf;
                    end
                    if (cmd.is_end)
                    begin
                        neg_next   = cmd.negative;
                        bad_next   = cmd.bad;
                        pad_next   = cmd.pad;
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                if (pad_reg == '0 || bad_reg || ovf_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    mag_next = step_sum[MAG_W-1:0];
                    ovf_next = step_ovf;
                    pad_next = pad_reg - 1'b1;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_next.ok    = !bad_reg && !ovf_reg && in_range;
                    out_next.limb0 = out_next.ok ? res_full[0*LIMB_W +: LIMB_W] : '0;
                    out_next.limb1 = out_next.ok ? res_full[1*LIMB_W +: LIMB_W] : '0;
                    out_next.limb2 = out_next.ok ? res_full[2*LIMB_W +: LIMB_W] : '0;
                    out_next.limb3 = out_next.ok ? res_full[3*LIMB_W +: LIMB_W] : '0;
                    out_valid_next = 1'b1;
                    mag_next       = '0;
                    ovf_next       = 1'b0;
                    state_next     = S_RUN;
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            mag_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mag_reg       <= mag_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        bad_reg <= bad_next;
        pad_reg <= pad_next;
        out_reg <= out_next;
    end

endmodule

FILE: hdl/decimal_string_to_fixed_point.sv
// Decimal text to two's-complement scaled integer parser, top level.
// Holds the configuration registers and connects classifier, queue and
// accumulator. Depends on dcs_pkg, dcs_front, dcs_queue and dcs_back.
//
// Characters enter as words on the push/full side, one per cycle while full
// is low. Each string ends with a word whose is_last is set; that word yields
// one result word on the empty/pop side, all other words yield none.
// Digit and end words pass through a four-entry queue to the accumulator,
// which takes one per cycle while it runs, so strings stream at one character
// per cycle while the queue has room. After the last character the accumulator
// multiplies by ten once per cycle for each missing fraction place (up to the
// scale), then checks the range, applies the sign and registers the result.
// The accumulator takes no words while it pads and finishes a string; the
// queue absorbs up to four words meanwhile.
// One result register sits at the output; while it is held by a stalled
// receiver the next string's digits keep flowing until the queue fills.
// Configuration writes (scale at index 0, width_mode at index 1) are always
// ready and should be made only while the block is idle.
// Reset clears the parse state (not the sign, error and pad registers), empties
// the result register and sets scale to 0 and width_mode to the 128-bit range.
module decimal_string_to_fixed_point
    import dcs_pkg::*;
#(
    parameter int LIMB_COUNT = LIMB_COUNT_DEF,
    parameter int MAX_SCALE  = MAX_SCALE_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  dcs_in_t               item,
    output logic                  empty,
    input  logic                  pop,
    output dcs_out_t              result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [SCALE_W-1:0] scale_reg;
    logic [MODE_W-1:0]  width_mode_reg;
    logic               take;
    logic               cmd_push;
    dcs_cmd_t           front_cmd;
    dcs_cmd_t           back_cmd;
    logic               cmd_pop;
    logic               queue_empty;

    assign cfg_ready = 1'b1;
    assign take      = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg      <= SCALE_RESET;
            width_mode_reg <= MODE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SCALE:      scale_reg      <= cfg_data[SCALE_W-1:0];
                REG_WIDTH_MODE: width_mode_reg <= cfg_data[MODE_W-1:0];
                default:        ;
            endcase
        end
    end

    dcs_front #(
        .MAX_SCALE (MAX_SCALE)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .item     (item),
        .scale    (scale_reg),
        .cmd_push (cmd_push),
        .cmd      (front_cmd)
    );

    dcs_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (front_cmd),
        .rd_en   (cmd_pop),
        .rd_data (back_cmd),
        .full    (full),
        .empty   (queue_empty)
    );

    dcs_back #(
        .LIMB_COUNT (LIMB_COUNT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (!queue_empty),
        .cmd        (back_cmd),
        .cmd_pop    (cmd_pop),
        .width_mode (width_mode_reg),
        .pop        (pop),
        .empty      (empty),
        .result     (result)
    );

endmodule

FILE: sim/decimal_string_to_fixed_point_tb.sv
// Self-checking testbench for the decimal string to fixed point parser.
// Streams decimal texts through the block and checks every result word
// against a built-in model of the parser. Depends on dcs_pkg and the RTL.
module decimal_string_to_fixed_point_tb;
    import dcs_pkg::*;

    localparam int unsigned PHASE_ITEMS   = 205;
    localparam int unsigned SETTLE_CYCLES = 100;
    localparam int unsigned QUIET_LIMIT   = 3000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    dcs_in_t               item = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    dcs_out_t              result;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Text words waiting to be sent and result words waiting to arrive.
    dcs_in_t  text_items[$];
    dcs_out_t expected_results[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned items_queued = 0;
    int unsigned str_len = 0;
    int unsigned strings_sent = 0;
    int unsigned settings_used = 0;
    int unsigned results_checked = 0;
    int unsigned in_range = 0;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;

    // Parser model state and its copy of the registers.
    logic [255:0]       acc_value = '0;
    bit                 past_lead, is_negative, got_digit, got_dot, parse_failed;
    int unsigned        frac_digits = 0;
    logic [SCALE_W-1:0] scale_reg = SCALE_RESET;
    logic [MODE_W-1:0]  mode_reg = MODE_RESET;

    decimal_string_to_fixed_point i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int unsigned acc_width();
        return (mode_reg >= MODE_256) ? 256 : 128;
    endfunction

    function automatic int unsigned out_width();
        case (mode_reg)
            MODE_64:  return 64;
            MODE_128: return 128;
            default:  return 256;
        endcase
    endfunction

    function automatic logic [255:0] acc_mask();
        return (acc_width() == 256) ? {256{1'b1}} : {128'b0, {128{1'b1}}};
    endfunction

    function automatic int unsigned kept_places();
        return (scale_reg > MAX_SCALE_DEF) ? MAX_SCALE_DEF : scale_reg;
    endfunction

    // value*10+digit within the accumulator width; returns 1 on a carry out.
    function automatic bit mul_add(int unsigned digit);
        logic [259:0] wide;
        logic [255:0] m;
        m = acc_mask();
        wide = 260'(acc_value & m) * 10 + digit;
        acc_value = (acc_value & ~m) | (wide[255:0] & m);
        return (wide >> acc_width()) != 0;
    endfunction

    function automatic void clear_number();
        acc_value = '0;
        past_lead = 1'b0;
        is_negative = 1'b0;
        got_digit = 1'b0;
        got_dot = 1'b0;
        frac_digits = 0;
        parse_failed = 1'b0;
    endfunction

    function automatic void take_char(logic [CHAR_W-1:0] c);
        if (!past_lead) begin
            if (c == CH_SPACE || c == CH_TAB)
                return;
            past_lead = 1'b1;
            if (c == CH_PLUS || c == CH_MINUS) begin
                is_negative = (c == CH_MINUS);
                return;
            end
        end
        if (c == CH_DOT) begin
            if (got_dot)
                parse_failed = 1'b1;
            got_dot = 1'b1;
            return;
        end
        if (c < CH_ZERO || c > CH_NINE) begin
            parse_failed = 1'b1;
            return;
        end
        got_digit = 1'b1;
        if (got_dot) begin
            // Fraction digits past the scale are only syntax-checked.
            if (frac_digits >= kept_places())
                return;
            frac_digits++;
        end
        if (mul_add(c - CH_ZERO))
            parse_failed = 1'b1;
    endfunction

    // Pads the fraction, checks the range and applies the sign.
    function automatic bit close_number(output logic [255:0] v);
        logic [256:0] lim;
        int unsigned n;
        v = '0;
        if (parse_failed || !got_digit)
            return 1'b0;
        while (frac_digits < kept_places()) begin
            if (mul_add(0))
                return 1'b0;
            frac_digits++;
        end
        n = out_width();
        v = acc_value & acc_mask();
        lim = 257'(1) << (n - 1);
        if ({1'b0, v} > lim || ({1'b0, v} == lim && !is_negative))
            return 1'b0;
        if (is_negative)
            v = ~v + 1'b1;
        if (n < 256)
            v &= (256'(1) << n) - 1'b1;
        return 1'b1;
    endfunction

    function automatic bit parse_char(dcs_in_t it, output dcs_out_t res);
        logic [255:0] v;
        bit good;
        res = '0;
        if (it.char_present && !parse_failed)
            take_char(it.char_code);
        if (!it.is_last)
            return 1'b0;
        good = close_number(v);
        if (!good)
            v = '0;
        res.limb0 = v[63:0];
        res.limb1 = v[127:64];
        res.limb2 = v[191:128];
        res.limb3 = v[255:192];
        res.ok = good;
        clear_number();
        return 1'b1;
    endfunction

    function automatic void put_char(logic [CHAR_W-1:0] c);
        dcs_in_t w;
        w.char_code = c;
        w.char_present = 1'b1;
        w.is_last = 1'b0;
        text_items.push_back(w);
        items_queued++;
        str_len++;
    endfunction

    // A word that carries no character.
    function automatic void put_gap();
        dcs_in_t w;
        w.char_code = 8'($urandom_range(0, 255));
        w.char_present = 1'b0;
        w.is_last = 1'b0;
        text_items.push_back(w);
        items_queued++;
        str_len++;
    endfunction

    // Ends the string either on its last word or with an extra empty word.
    function automatic void close_string();
        if (str_len == 0 || text_items.size() == 0 || $urandom_range(0, 3) == 0) begin
            put_gap();
            text_items[text_items.size() - 1].char_present = 1'b0;
        end
        text_items[text_items.size() - 1].is_last = 1'b1;
        str_len = 0;
        strings_sent++;
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++)
            put_char(s[i]);
    endfunction

    function automatic void put_digits(int unsigned count);
        for (int unsigned i = 0; i < count; i++) begin
            if ($urandom_range(0, 19) == 0)
                put_gap();
            put_char(8'(CH_ZERO + $urandom_range(0, 9)));
        end
    endfunction

    function automatic void put_number();
        int unsigned int_len;
        repeat ($urandom_range(0, 2))
            put_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
        case ($urandom_range(0, 2))
            1: put_char(CH_PLUS);
            2: put_char(CH_MINUS);
            default: ;
        endcase
        int_len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 80) : $urandom_range(1, 6);
        put_digits(int_len);
        if ($urandom_range(0, 1)) begin
            put_char(CH_DOT);
            put_digits(($urandom_range(0, 5) == 0) ? $urandom_range(0, kept_places() + 2)
                                                   : $urandom_range(0, 4));
        end
        close_string();
    endfunction

    // Texts whose scaled value sits at or near the edge of the result range.
    function automatic void put_extreme();
        logic [255:0] mag;
        logic [7:0]   digits[$];
        int           n, s, pick;
        n = out_width();
        s = kept_places();
        pick = $urandom_range(0, 4);
        mag = '0;
        case (pick)
            0, 1, 2: mag = (256'(1) << (n - 1)) + pick - 1;
            3:       mag = acc_mask();
            default:
            begin
                for (int i = 0; i < 8; i++)
                    mag = {mag[223:0], 32'($urandom)};
                mag = mag >> $urandom_range(256 - n, 255);
            end
        endcase
        do
        begin
            digits.push_front(8'(mag % 10) + CH_ZERO);
            mag = mag / 10;
        end
        while (mag != 0);
        while (digits.size() < s + 1)
            digits.push_front(CH_ZERO);
        if ($urandom_range(0, 3) != 0)
            put_char(CH_MINUS);
        else if ($urandom_range(0, 1))
            put_char(CH_PLUS);
        for (int i = 0; i < digits.size(); i++) begin
            if (s != 0 && i == digits.size() - s)
                put_char(CH_DOT);
            put_char(digits[i]);
        end
        if ($urandom_range(0, 3) == 0) begin
            if (s == 0)
                put_char(CH_DOT);
            put_digits($urandom_range(1, 3));
        end
        close_string();
    endfunction

    function automatic void put_noise();
        repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: put_char(8'($urandom_range(0, 255)));
                4:          put_gap();
                5:          put_char(CH_DOT);
                6:          put_char($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                7:          put_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
                default:    put_char(8'(CH_ZERO + $urandom_range(0, 9)));
            endcase
        end
        close_string();
    endfunction

    function automatic void fill_phase(int unsigned target);
        int unsigned goal;
        int unsigned pick;
        goal = items_queued + target;
        while (items_queued < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
                put_number();
            else if (pick < 80)
                put_extreme();
            else
                put_noise();
        end
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_SCALE:      scale_reg = data[SCALE_W-1:0];
            REG_WIDTH_MODE: mode_reg = data[MODE_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    // Waits until every word is sent and every result is back, then lets
    // any padding still running in the block finish.
    task automatic settle();
        do
            @(negedge clk);
        while (text_items.size() != 0 || push || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(logic [7:0] scale_data, logic [7:0] mode_data,
                             int unsigned send_pct, int unsigned recv_pct);
        write_reg(REG_SCALE, scale_data);
        write_reg(REG_WIDTH_MODE, mode_data);
        settings_used++;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        fill_phase(PHASE_ITEMS);
        settle();
    endtask

    always @(posedge clk) begin : drive_proc
        dcs_out_t res;
        if (!rst_n) begin
            push <= 1'b0;
        end
        else begin
            if (push && !full && parse_char(item, res))
                expected_results.push_back(res);
            if (!push || !full) begin
                if (text_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    item <= text_items.pop_front();
                    push <= 1'b1;
                end
                else begin
                    push <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin : check_proc
        dcs_out_t want;
        if (!rst_n) begin
            pop <= 1'b0;
        end
        else begin
            if (pop && !empty) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result word with none expected, expected nothing, got %h",
                             $time, result);
                    mismatches++;
                end
                else begin
                    want = expected_results.pop_front();
                    check_field("limb0", want.limb0, result.limb0);
                    check_field("limb1", want.limb1, result.limb1);
                    check_field("limb2", want.limb2, result.limb2);
                    check_field("limb3", want.limb3, result.limb3);
                    check_field("ok", 64'(want.ok), 64'(result.ok));
                    results_checked++;
                    if (want.ok)
                        in_range++;
                end
            end
            pop <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        clear_number();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 28;
        recv_idle_pct = 83;
        write_reg(REG_SCALE, 8'd2);
        write_reg(REG_WIDTH_MODE, 8'(MODE_64));
        settings_used++;
        put_text(" \t-1.5");
        close_string();
        put_text("-0");
        close_string();
        put_text("1..");
        close_string();
        close_string();
        put_char(CH_PLUS);
        close_string();
        put_text("7 ");
        close_string();
        put_text("- 4");
        close_string();
        put_text("9.999");
        close_string();
        put_char(8'h33);
        put_gap();
        close_string();
        put_char(8'hFF);
        close_string();
        settle();

        // Scale lowered while a string is open: no padding at its end.
        write_reg(REG_SCALE, 8'd3);
        put_text("1.234");
        settle();
        write_reg(REG_SCALE, 8'd1);
        settings_used++;
        close_string();
        settle();

        run_phase(8'h00, 8'h00, 28, 83);
        run_phase(8'h02, 8'h01, 28, 83);
        run_phase(8'h4C, 8'h02, 28, 83);
        run_phase(8'h92, 8'hFC, 83, 28);
        run_phase(8'hFF, 8'h03, 83, 28);
        run_phase(8'h05, 8'h7D, 83, 28);
        run_phase(8'h26, 8'h02, 0, 0);
        run_phase(8'h4C, 8'h00, 0, 0);
        run_phase(8'h00, 8'hFE, 0, 0);

        $display("tb: %0d strings in %0d words over %0d register settings",
                 strings_sent, items_queued, settings_used);
        $display("tb: %0d result words checked, %0d of them valid and in range",
                 results_checked, in_range);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("tb: success");
        end
        else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
